@@ hdl/block_buffer_lookup_lru_alloc_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the block buffer lookup core.
// Each macro expands to one labeled concurrent assertion on the rising clock.
// ---------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_LOOKUP_LRU_ALLOC_CORE_ASSERT_SVH
`define BLOCK_BUFFER_LOOKUP_LRU_ALLOC_CORE_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define BBL_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define BBL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/bbl_pkg.sv @@
// ---------------------------------------------------------------------------
// bbl_pkg
// Types, codes and constants shared by the block buffer lookup core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbl_pkg;

   // Default size of the buffer pool.
   localparam int NUM_ENTRIES_DEF = 32;

   // Widest entry index the pool can need (up to 256 entries).
   localparam int IDX_MAX_W = 8;

   // Operation codes.
   localparam logic [1:0] FUNC_GET     = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_PIN     = 2'd2;
   localparam logic [1:0] FUNC_UNPIN   = 2'd3;

   // Result status codes.
   localparam logic [2:0] STAT_HIT     = 3'd0;
   localparam logic [2:0] STAT_ALLOC   = 3'd1;
   localparam logic [2:0] STAT_NOFREE  = 3'd2;
   localparam logic [2:0] STAT_DONE    = 3'd3;
   localparam logic [2:0] STAT_REFUSED = 3'd4;

   localparam logic [7:0] REFS_MAX = 8'hFF;

   // One request transfer.
   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  device;
      logic [31:0] block_number;
      logic [4:0]  buffer_index;
      logic [31:0] now;
   } req_type;

   // One response transfer.
   typedef struct packed {
      logic [2:0] status;
      logic [4:0] entry;
      logic [7:0] reference_count;
   } rsp_type;

   // One stored buffer entry.
   typedef struct packed {
      logic [7:0]  device;
      logic [31:0] block;
      logic [7:0]  refs;
      logic        linked;
      logic [31:0] stamp;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   // What the scan unit has found so far for the current request.
   typedef struct packed {
      logic                 hit;
      logic [IDX_MAX_W-1:0] hit_idx;
      logic [7:0]           hit_refs;
      logic [31:0]          hit_stamp;
      logic                 free;
      logic [IDX_MAX_W-1:0] free_idx;
      logic [31:0]          free_stamp;
      row_type              last_row;
   } scan_status_type;

endpackage

`default_nettype wire

@@ hdl/bbl_ram.sv @@
// ---------------------------------------------------------------------------
// bbl_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/bbl_scan.sv @@
// ---------------------------------------------------------------------------
// bbl_scan
// Walks the entries read from the buffer memory one per cycle and keeps the
// first linked match and the oldest free entry for the current request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbl_scan #(
   parameter int NUM_ENTRIES = bbl_pkg::NUM_ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           clear,
   input  wire logic [31:0]                    clear_now,
   input  wire logic                           in_valid,
   input  wire logic [$clog2(NUM_ENTRIES)-1:0] in_idx,
   input  wire bbl_pkg::row_type               in_row,
   input  wire logic [7:0]                     req_device,
   input  wire logic [31:0]                    req_block,
   output bbl_pkg::scan_status_type            status
);

   logic                          hit_ff, hit_in;
   logic [bbl_pkg::IDX_MAX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [7:0]                    hit_refs_ff, hit_refs_in;
   logic [31:0]                   hit_stamp_ff, hit_stamp_in;
   logic                          free_ff, free_in;
   logic [bbl_pkg::IDX_MAX_W-1:0] free_idx_ff, free_idx_in;
   logic [31:0]                   best_ff, best_in;
   bbl_pkg::row_type              last_row_ff, last_row_in;

   logic is_match;
   logic is_free;

   // Match and free tests on the entry that arrives this cycle.
   assign is_match = in_row.linked && (in_row.device == req_device) &&
                     (in_row.block == req_block);
   assign is_free  = (in_row.refs == 8'd0) && (in_row.stamp <= best_ff);

   // Keep the lowest-index match; a free entry with an equal or older stamp
   // replaces the current pick, so ties go to the later index.
   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_refs_in  = hit_refs_ff;
      hit_stamp_in = hit_stamp_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      best_in      = best_ff;
      last_row_in  = last_row_ff;
      if (clear) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
         best_in = clear_now;
      end else if (in_valid) begin
         last_row_in = in_row;
         if (is_match && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = bbl_pkg::IDX_MAX_W'(in_idx);
            hit_refs_in  = in_row.refs;
            hit_stamp_in = in_row.stamp;
         end
         if (is_free) begin
            free_in     = 1'b1;
            free_idx_in = bbl_pkg::IDX_MAX_W'(in_idx);
            best_in     = in_row.stamp;
         end
      end
   end

   // Tracker registers; only the found flags need a reset.
   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_refs_ff  <= hit_refs_in;
      hit_stamp_ff <= hit_stamp_in;
      free_idx_ff  <= free_idx_in;
      best_ff      <= best_in;
      last_row_ff  <= last_row_in;
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
   end

   assign status.hit        = hit_ff;
   assign status.hit_idx    = hit_idx_ff;
   assign status.hit_refs   = hit_refs_ff;
   assign status.hit_stamp  = hit_stamp_ff;
   assign status.free       = free_ff;
   assign status.free_idx   = free_idx_ff;
   assign status.free_stamp = best_ff;
   assign status.last_row   = last_row_ff;

endmodule

`default_nettype wire

@@ hdl/block_buffer_lookup_lru_alloc_core.sv @@
// ---------------------------------------------------------------------------
// block_buffer_lookup_lru_alloc_core
// Disk block buffer pool: lookup with least-recently-released allocation,
// reference counting, release, pin and unpin.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel (valid/stall) as one packed struct;
//   each request produces exactly one response on the rsp_ channel.
//   A get reads every entry of the buffer memory, one entry per cycle, to
//   find a linked match and the oldest free entry; release, pin and unpin
//   read the one addressed entry. The entry memory has a single read port;
//   one request is worked on at a time, and the next one is taken the cycle
//   after the previous one has written its result.
//   The response sits in an output register; while the receiver stalls, the
//   block still takes a new request and stops only when that request's
//   response is ready and the register is still full.
//   Reset clears all entries at once through per-entry valid bits: an entry
//   not written since reset reads as all zero. No clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_buffer_lookup_lru_alloc_core #(
   parameter int NUM_ENTRIES = bbl_pkg::NUM_ENTRIES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bbl_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bbl_pkg::rsp_type      rsp_payload
);

`include "block_buffer_lookup_lru_alloc_core_assert.svh"

   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type             state_ff, state_in;
   bbl_pkg::req_type      req_ff, req_in;
   logic [CNT_W-1:0]      issue_cnt_ff, issue_cnt_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  rd_last_ff, rd_last_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [NUM_ENTRIES-1:0] row_valid_ff, row_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bbl_pkg::rsp_type      rsp_ff, rsp_in;

   logic                  req_accept;
   logic                  is_get;
   logic [CNT_W-1:0]      issue_limit;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [bbl_pkg::ROW_W-1:0] ram_q;
   bbl_pkg::row_type      rd_row;
   bbl_pkg::scan_status_type scan_st;
   logic                  out_free;
   logic                  finish;
   logic                  do_write;
   logic                  ram_we;
   logic [IDX_W-1:0]      wr_addr;
   bbl_pkg::row_type      wr_row;
   bbl_pkg::rsp_type      res;
   bbl_pkg::row_type      cur;
   logic                  out_of_range;
   logic [7:0]            refs_dec;

   // Request side handshake: one request in flight.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Read sequencing: every entry for a get, the addressed one otherwise.
   assign is_get      = (req_ff.func == bbl_pkg::FUNC_GET);
   assign issue_limit = is_get ? CNT_W'(NUM_ENTRIES) : CNT_W'(1);
   assign rd_en       = (state_ff == ST_SCAN) && (issue_cnt_ff < issue_limit);
   assign rd_addr     = is_get ? issue_cnt_ff[IDX_W-1:0] : IDX_W'(req_ff.buffer_index);

   // Entries never written since reset read as zero.
   assign rd_row = rd_ok_ff ? bbl_pkg::row_type'(ram_q) : '0;

   bbl_ram #(
      .WIDTH (bbl_pkg::ROW_W),
      .DEPTH (NUM_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   bbl_scan #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (req_accept),
      .clear_now  (req_payload.now),
      .in_valid   (rd_pend_ff),
      .in_idx     (rd_idx_ff),
      .in_row     (rd_row),
      .req_device (req_ff.device),
      .req_block  (req_ff.block_number),
      .status     (scan_st)
   );

   // Outcome of the request once all reads are in.
   assign cur          = scan_st.last_row;
   assign out_of_range = (32'(req_ff.buffer_index) >= 32'(NUM_ENTRIES));
   assign refs_dec     = cur.refs - 8'd1;

   always_comb begin
      do_write = 1'b0;
      wr_addr  = IDX_W'(req_ff.buffer_index);
      wr_row   = cur;
      res      = '0;
      if (is_get) begin
         if (scan_st.hit) begin
            res.entry = 5'(scan_st.hit_idx);
            wr_addr   = IDX_W'(scan_st.hit_idx);
            if (scan_st.hit_refs == bbl_pkg::REFS_MAX) begin
               res.status          = bbl_pkg::STAT_REFUSED;
               res.reference_count = bbl_pkg::REFS_MAX;
            end else begin
               do_write            = 1'b1;
               res.status          = bbl_pkg::STAT_HIT;
               res.reference_count = scan_st.hit_refs + 8'd1;
               wr_row.device       = req_ff.device;
               wr_row.block        = req_ff.block_number;
               wr_row.refs         = scan_st.hit_refs + 8'd1;
               wr_row.linked       = 1'b1;
               wr_row.stamp        = scan_st.hit_stamp;
            end
         end else if (scan_st.free) begin
            do_write            = 1'b1;
            res.status          = bbl_pkg::STAT_ALLOC;
            res.entry           = 5'(scan_st.free_idx);
            res.reference_count = 8'd1;
            wr_addr             = IDX_W'(scan_st.free_idx);
            wr_row.device       = req_ff.device;
            wr_row.block        = req_ff.block_number;
            wr_row.refs         = 8'd1;
            wr_row.linked       = 1'b1;
            wr_row.stamp        = scan_st.free_stamp;
         end else begin
            res.status = bbl_pkg::STAT_NOFREE;
         end
      end else begin
         res.entry = req_ff.buffer_index;
         if (out_of_range) begin
            res.status = bbl_pkg::STAT_REFUSED;
         end else if (req_ff.func == bbl_pkg::FUNC_PIN) begin
            if (cur.refs == bbl_pkg::REFS_MAX) begin
               res.status          = bbl_pkg::STAT_REFUSED;
               res.reference_count = bbl_pkg::REFS_MAX;
            end else begin
               do_write            = 1'b1;
               res.status          = bbl_pkg::STAT_DONE;
               res.reference_count = cur.refs + 8'd1;
               wr_row.refs         = cur.refs + 8'd1;
            end
         end else if (cur.refs == 8'd0) begin
            res.status = bbl_pkg::STAT_REFUSED;
         end else begin
            // Release and unpin both lower the count; release also stamps
            // the entry and unlinks it when the count reaches zero.
            do_write            = 1'b1;
            res.status          = bbl_pkg::STAT_DONE;
            res.reference_count = refs_dec;
            wr_row.refs         = refs_dec;
            if (req_ff.func == bbl_pkg::FUNC_RELEASE) begin
               wr_row.stamp = req_ff.now;
               if (refs_dec == 8'd0) begin
                  wr_row.linked = 1'b0;
               end
            end
         end
      end
   end

   // Write-back happens together with the response transfer into the
   // output register.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = (state_ff == ST_RESULT) && out_free;
   assign ram_we   = finish && do_write;

   // Next-state logic.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_pend_in   = rd_en;
      rd_last_in   = rd_en && (issue_cnt_ff == issue_limit - CNT_W'(1));
      rd_idx_in    = rd_addr;
      rd_ok_in     = row_valid_ff[rd_addr];
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in     = ST_SCAN;
               req_in       = req_payload;
               issue_cnt_in = '0;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
            if (rd_pend_ff && rd_last_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = res;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (ram_we) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rd_idx_ff <= rd_idx_in;
      rd_ok_ff  <= rd_ok_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_cnt_ff <= '0;
         rd_pend_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rd_last_ff   <= rd_last_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A write-back never collides with a read of the same memory.
   `BBL_ASSERT_IMPL(a_wr_no_read, clock, reset, ram_we, !rd_en, "write during read")
   // A new response only comes out of the result step.
   `BBL_ASSERT_IMPL(a_rsp_from_result, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_RESULT, "response outside result step")
   // An allocation always reports a single reference.
   `BBL_ASSERT_IMPL(a_alloc_one, clock, reset,
      rsp_valid_ff && (rsp_ff.status == bbl_pkg::STAT_ALLOC),
      rsp_ff.reference_count == 8'd1, "allocation count not one")
   // The last read data moves the sequencer to the result step.
   `BBL_ASSERT_NEXT(a_scan_done, clock, reset,
      (state_ff == ST_SCAN) && rd_pend_ff && rd_last_ff,
      state_ff == ST_RESULT, "scan did not finish")

endmodule

`default_nettype wire

@@ sim/buffer_pool_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// buffer_pool_checker
// Watches the request and response channels of the block buffer lookup core.
// It keeps its own copy of the buffer pool, works out the response of every
// accepted request and compares each accepted response with the oldest one
// still awaited.
// ---------------------------------------------------------------------------

module buffer_pool_checker
   import bbl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_payload,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_payload,
   output int unsigned  fail_count,
   output int unsigned  pending_count
);

   localparam int POOL_SIZE = NUM_ENTRIES_DEF;

   // Shadow copy of the buffer pool.
   logic [7:0]  pool_device [POOL_SIZE];
   logic [31:0] pool_block  [POOL_SIZE];
   logic [7:0]  pool_refs   [POOL_SIZE];
   logic        pool_linked [POOL_SIZE];
   logic [31:0] pool_stamp  [POOL_SIZE];

   rsp_type     awaited_rsp_q[$];
   int unsigned mismatches;
   int unsigned awaited;

   assign fail_count    = mismatches;
   assign pending_count = awaited;

   // Applies one request to the shadow pool and returns the response it must
   // produce.
   function automatic rsp_type predict_buffer_op(input req_type r);
      rsp_type     res;
      logic        found;
      logic [4:0]  pick;
      logic [31:0] best;
      int          k;
      res   = '0;
      found = 1'b0;
      pick  = '0;
      if (r.func == FUNC_GET) begin
         // Lookup: the lowest linked entry with the same device and block.
         for (k = 0; k < POOL_SIZE; k++) begin
            if (!found && pool_linked[k] && pool_device[k] == r.device &&
                pool_block[k] == r.block_number) begin
               found = 1'b1;
               pick  = 5'(k);
            end
         end
         if (found) begin
            res.entry = pick;
            if (pool_refs[pick] == REFS_MAX) begin
               res.status          = STAT_REFUSED;
               res.reference_count = REFS_MAX;
            end else begin
               pool_refs[pick]     = pool_refs[pick] + 8'd1;
               res.status          = STAT_HIT;
               res.reference_count = pool_refs[pick];
            end
            return res;
         end
         // Miss: oldest free entry whose stamp is not after now, ties to the
         // highest index.
         best = r.now;
         for (k = 0; k < POOL_SIZE; k++) begin
            if (pool_refs[k] == 8'd0 && pool_stamp[k] <= best) begin
               found = 1'b1;
               pick  = 5'(k);
               best  = pool_stamp[k];
            end
         end
         if (!found) begin
            res.status = STAT_NOFREE;
            return res;
         end
         pool_device[pick]   = r.device;
         pool_block[pick]    = r.block_number;
         pool_refs[pick]     = 8'd1;
         pool_linked[pick]   = 1'b1;
         res.status          = STAT_ALLOC;
         res.entry           = pick;
         res.reference_count = 8'd1;
         return res;
      end

      res.entry = r.buffer_index;
      if (int'(r.buffer_index) >= POOL_SIZE) begin
         res.status = STAT_REFUSED;
         return res;
      end
      pick = r.buffer_index;

      if (r.func == FUNC_PIN) begin
         if (pool_refs[pick] == REFS_MAX) begin
            res.status          = STAT_REFUSED;
            res.reference_count = REFS_MAX;
         end else begin
            pool_refs[pick]     = pool_refs[pick] + 8'd1;
            res.status          = STAT_DONE;
            res.reference_count = pool_refs[pick];
         end
         return res;
      end

      // Release and unpin lower the count; only a release unlinks and stamps.
      if (pool_refs[pick] == 8'd0) begin
         res.status = STAT_REFUSED;
         return res;
      end
      pool_refs[pick] = pool_refs[pick] - 8'd1;
      if (r.func == FUNC_RELEASE) begin
         if (pool_refs[pick] == 8'd0)
            pool_linked[pick] = 1'b0;
         pool_stamp[pick] = r.now;
      end
      res.status          = STAT_DONE;
      res.reference_count = pool_refs[pick];
      return res;
   endfunction

   // Monitor both channels at the rising edge.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         foreach (pool_refs[k]) begin
            pool_device[k] = '0;
            pool_block[k]  = '0;
            pool_refs[k]   = '0;
            pool_linked[k] = 1'b0;
            pool_stamp[k]  = '0;
         end
         awaited_rsp_q.delete();
         mismatches = 0;
      end else begin
         // Check the response transfer against the oldest awaited one.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp_q.size() == 0) begin
               mismatches++;
               $display("%0t: response with none awaited, got status %0d entry %0d refs %0d",
                        $time, rsp_payload.status, rsp_payload.entry,
                        rsp_payload.reference_count);
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_payload.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_payload.status);
               end
               if (rsp_payload.entry !== want.entry) begin
                  mismatches++;
                  $display("%0t: entry mismatch, expected %0d, got %0d",
                           $time, want.entry, rsp_payload.entry);
               end
               if (rsp_payload.reference_count !== want.reference_count) begin
                  mismatches++;
                  $display("%0t: reference count mismatch, expected %0d, got %0d",
                           $time, want.reference_count, rsp_payload.reference_count);
               end
            end
         end
         // Predict the response of a request transfer.
         if (req_valid && !req_stall)
            awaited_rsp_q.push_back(predict_buffer_op(req_payload));
      end
      awaited = awaited_rsp_q.size();
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives the block buffer lookup core with a directed opening, a run of pins
// up to the count limit, and random request traffic in phases with and
// without idle cycles on either side. The checker beside the core predicts
// and compares every response; this module gives the verdict.
// ---------------------------------------------------------------------------

module tb_top;
   import bbl_pkg::*;

   localparam int          RANDOM_PER_PHASE = 400;
   localparam int          NUM_KEYS         = 48;
   localparam int          HOLD_CYCLES      = 300;
   localparam int          TAIL_CYCLES      = 60;
   localparam int unsigned CYCLE_LIMIT      = 1000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   int unsigned fail_count;
   int unsigned pending_count;

   // Idle rates in percent, set per phase by the stimulus process.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   logic        long_hold_go;
   logic        long_hold_done;

   // Tick counter and the pool of block keys that gets draw from.
   logic [31:0] tick;
   logic [7:0]  key_device [NUM_KEYS];
   logic [31:0] key_block  [NUM_KEYS];

   block_buffer_lookup_lru_alloc_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   buffer_pool_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Clock with a 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Builds one request.
   function automatic req_type make_req(input logic [1:0] func, input logic [7:0] device,
                                        input logic [31:0] block_number,
                                        input logic [4:0] buffer_index,
                                        input logic [31:0] now);
      req_type r;
      r.func         = func;
      r.device       = device;
      r.block_number = block_number;
      r.buffer_index = buffer_index;
      r.now          = now;
      return r;
   endfunction

   // Random request: most gets reuse a key so that hits and reuse happen, and
   // now mostly follows a slowly rising tick.
   function automatic req_type random_req();
      req_type     r;
      int unsigned roll;
      int unsigned sel;
      r.device       = 8'($urandom);
      r.block_number = $urandom;
      r.buffer_index = 5'($urandom);
      roll           = $urandom_range(0, 99);
      if (roll < 40)
         r.func = FUNC_GET;
      else if (roll < 75)
         r.func = FUNC_RELEASE;
      else if (roll < 87)
         r.func = FUNC_PIN;
      else
         r.func = FUNC_UNPIN;
      if (r.func == FUNC_GET && $urandom_range(0, 9) < 8) begin
         sel            = $urandom_range(0, NUM_KEYS - 1);
         r.device       = key_device[sel];
         r.block_number = key_block[sel];
      end
      tick = tick + $urandom_range(0, 3);
      roll = $urandom_range(0, 99);
      // Releases rarely take a random tick, since a late stamp locks the entry out.
      if (roll < 2 || (r.func != FUNC_RELEASE && roll < 5))
         r.now = $urandom;
      else if (roll < 8)
         r.now = $urandom_range(0, tick);
      else
         r.now = tick;
      return r;
   endfunction

   // One request transfer, after a random number of idle cycles.
   task automatic send_req(input req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Holds off new requests until every awaited response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off when asked for.
   initial begin : receiver
      int unsigned hold_left;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_stall      = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_go && !long_hold_done) begin
            if (hold_left == 0)
               hold_left = HOLD_CYCLES;
            hold_left--;
            if (hold_left == 0)
               long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // Watchdog on the total run length.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL block_buffer_lookup_lru_alloc_core");
      $finish;
   end

   // Stimulus and verdict.
   initial begin : stimulus
      int unsigned idle_of_phase  [4];
      int unsigned stall_of_phase [4];
      int          n;
      int          p;
      idle_of_phase  = '{0, 74, 0, 38};
      stall_of_phase = '{0, 0, 74, 38};
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      long_hold_go   = 1'b0;
      tick           = '0;
      foreach (key_device[k]) begin
         key_device[k] = 8'($urandom);
         key_block[k]  = $urandom;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening from the cleared pool.
      send_req(make_req(FUNC_GET, 8'h00, 32'h0, 5'd0, 32'h0));          // miss, top entry
      send_req(make_req(FUNC_GET, 8'h00, 32'h0, 5'd0, 32'h0));          // hit
      send_req(make_req(FUNC_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF));
      send_req(make_req(FUNC_RELEASE, 8'h00, 32'h0, 5'd31, 32'd5));
      send_req(make_req(FUNC_RELEASE, 8'h00, 32'h0, 5'd31, 32'd5));     // unlinks
      send_req(make_req(FUNC_RELEASE, 8'h00, 32'h0, 5'd31, 32'd5));     // refused at zero
      send_req(make_req(FUNC_UNPIN, 8'h00, 32'h0, 5'd0, 32'd6));        // refused at zero
      send_req(make_req(FUNC_PIN, 8'h00, 32'h0, 5'd0, 32'd6));
      send_req(make_req(FUNC_UNPIN, 8'h00, 32'h0, 5'd0, 32'd6));
      // A stamp after now keeps the released entry out of the choice.
      send_req(make_req(FUNC_GET, 8'h01, 32'h1, 5'd0, 32'd3));
      send_req(make_req(FUNC_GET, 8'h00, 32'h0, 5'd0, 32'd0));
      // Linked entry with count zero still hits, and is overwritten on reuse.
      send_req(make_req(FUNC_GET, 8'h02, 32'h7, 5'd0, 32'd9));
      send_req(make_req(FUNC_UNPIN, 8'h00, 32'h0, 5'd27, 32'd9));
      send_req(make_req(FUNC_GET, 8'h02, 32'h7, 5'd0, 32'd9));
      send_req(make_req(FUNC_UNPIN, 8'h00, 32'h0, 5'd27, 32'd9));
      send_req(make_req(FUNC_GET, 8'h03, 32'h9, 5'd0, 32'd1));
      send_req(make_req(FUNC_GET, 8'h02, 32'h7, 5'd0, 32'd1));
      send_req(make_req(FUNC_RELEASE, 8'h00, 32'h0, 5'd26, 32'hFFFF_FFFF));
      // Fields that pin and get ignore carry extreme values.
      send_req(make_req(FUNC_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd5, 32'd10));
      send_req(make_req(FUNC_GET, 8'h03, 32'h9, 5'd31, 32'd0));
      send_req(make_req(FUNC_RELEASE, 8'h00, 32'h0, 5'd26, 32'd10));
      wait_drained();

      // Pin the entry holding the all-ones key past the count limit, hit it
      // there, then release it all the way back down.
      tick = 32'd20;
      for (n = 0; n < 256; n++)
         send_req(make_req(FUNC_PIN, 8'($urandom), $urandom, 5'd30, tick));
      send_req(make_req(FUNC_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, tick));
      for (n = 0; n < 255; n++) begin
         tick = tick + 1;
         send_req(make_req(FUNC_RELEASE, 8'($urandom), $urandom, 5'd30, tick));
      end
      wait_drained();

      // Random traffic in idle phases; the first also holds the receiver off
      // for a long stretch while requests keep coming.
      for (p = 0; p < 4; p++) begin
         send_idle_pct  = idle_of_phase[p];
         recv_stall_pct = stall_of_phase[p];
         if (p == 0)
            long_hold_go = 1'b1;
         for (n = 0; n < RANDOM_PER_PHASE; n++)
            send_req(random_req());
         wait_drained();
      end

      recv_stall_pct = 0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS block_buffer_lookup_lru_alloc_core");
      else
         $display("FAIL block_buffer_lookup_lru_alloc_core");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/bbl_pkg.sv
hdl/bbl_ram.sv
hdl/bbl_scan.sv
hdl/block_buffer_lookup_lru_alloc_core.sv
sim/buffer_pool_checker.sv
sim/tb_top.sv
